@@ rtl/core/vibration_amfm_packet_decoder_core_assert.svh @@
// Assertion macros used by the decoder checker.
`ifndef VIBRATION_AMFM_PACKET_DECODER_CORE_ASSERT_SVH
`define VIBRATION_AMFM_PACKET_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define VAMFM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define VAMFM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also watches the reset itself.
`define VAMFM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/vamfm_pkg.sv @@
// Types, command tables and conversion functions of the vibration packet decoder.
package vamfm_pkg;

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 8;
   localparam int RSP_DATA_W = 64;

   // Largest values the result fields can take.
   localparam logic [15:0] AMP_ONE       = 16'd32768;
   localparam logic [14:0] LOW_FREQ_MAX  = 15'd20480;
   localparam logic [15:0] HIGH_FREQ_MAX = 16'd40960;

   // Offset log amplitudes below this give a zero amplitude.
   localparam logic [8:0] AMP_FLOOR_U = 9'd2;

   localparam logic signed [8:0] AMP_DFLT = -9'sd256;
   localparam logic signed [8:0] AMP_MAX  = 9'sd0;
   localparam logic signed [7:0] FREQ_DFLT = 8'sd0;
   localparam logic signed [8:0] FREQ_MIN  = -9'sd64;
   localparam logic signed [8:0] FREQ_MAX  = 9'sd64;

   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_ONE5   = 3'd1,
      OP_ONE7   = 3'd2,
      OP_THREE7 = 3'd3,
      OP_TWO5   = 3'd4,
      OP_TWO7   = 3'd5,
      OP_THREE5 = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ACT_KEEP  = 2'd0,
      ACT_DFLT  = 2'd1,
      ACT_SUBST = 2'd2,
      ACT_ADD   = 2'd3
   } act_type;

   typedef struct packed {
      op_type          op;
      logic [1:0]      target;
      logic [2:0][4:0] code_lo;
      logic [2:0][4:0] code_hi;
      logic [6:0]      am7_lo;
      logic [6:0]      fm7_lo;
      logic [6:0]      am7_hi;
      logic [6:0]      fm7_hi;
   } pkt_type;

   typedef struct packed {
      logic emit;
      logic last;
      logic ld_la;
      logic ld_lf;
      logic ld_ha;
      logic ld_hf;
      logic cmd_lo_en;
      logic cmd_hi_en;
   } step_ctl_type;

   localparam act_type AM_ACT [32] = '{
      ACT_DFLT,  ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_SUBST,
      ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,
      ACT_KEEP,  ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_KEEP,
      ACT_KEEP,  ACT_KEEP,  ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_ADD
   };

   localparam logic signed [8:0] AM_VAL [32] = '{
      9'sd0,    9'sd0,    -9'sd16,  -9'sd32,  -9'sd48,  -9'sd64,  -9'sd80,  -9'sd96,
      -9'sd112, -9'sd128, -9'sd144, -9'sd160, 9'sd0,    9'sd0,    9'sd0,    9'sd0,
      9'sd0,    9'sd4,    9'sd4,    9'sd4,    9'sd1,    9'sd1,    9'sd1,    9'sd0,
      9'sd0,    9'sd0,    -9'sd1,   -9'sd1,   -9'sd1,   -9'sd4,   -9'sd4,   -9'sd4
   };

   localparam act_type FM_ACT [32] = '{
      ACT_DFLT,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,
      ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_SUBST,
      ACT_SUBST, ACT_ADD,   ACT_KEEP,  ACT_ADD,   ACT_ADD,   ACT_KEEP,  ACT_ADD,   ACT_ADD,
      ACT_KEEP,  ACT_ADD,   ACT_ADD,   ACT_KEEP,  ACT_ADD,   ACT_ADD,   ACT_KEEP,  ACT_ADD
   };

   localparam logic signed [4:0] FM_VAL [32] = '{
      5'sd0,   5'sd0,  5'sd0,   5'sd0,  5'sd0,  5'sd0,   5'sd0,  5'sd0,
      5'sd0,   5'sd0,  5'sd0,   5'sd0,  -5'sd12, -5'sd6, 5'sd0,  5'sd6,
      5'sd12,  5'sd1,  5'sd0,   -5'sd1, 5'sd1,  5'sd0,   -5'sd1, 5'sd1,
      5'sd0,   -5'sd1, 5'sd1,   5'sd0,  -5'sd1, 5'sd1,   5'sd0,  -5'sd1
   };

   typedef logic [31:0][63:0] pow_tab_type;
   typedef logic [31:0][16:0] amp_tab_type;
   typedef logic [31:0][17:0] freq_tab_type;

   // Rounded product of two Q2.62 values.
   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << 61);
      return p[125:62];
   endfunction

   // Floor square root of a Q2.62 value in [1, 2] by bisection.
   function automatic logic [63:0] sqrt_q62(logic [63:0] v);
      logic [127:0] tgt;
      logic [127:0] sq;
      logic [63:0]  lo;
      logic [63:0]  hi;
      logic [63:0]  mid;
      tgt = {v, 64'd0} >> 2;
      lo  = 64'd1 << 62;
      hi  = (64'd1 << 63) - 64'd1;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 64'd1) >> 1);
         sq  = {64'd0, mid} * {64'd0, mid};
         if (sq <= tgt) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      return lo;
   endfunction

   // 2^(r/32) in Q2.62, built from repeated square roots of two.
   function automatic pow_tab_type build_pow_tab();
      logic [5:0][63:0] root;
      logic [63:0]      t;
      pow_tab_type      tab;
      root[0] = 64'd1 << 63;
      for (int k = 1; k < 6; k++) begin
         root[k] = sqrt_q62(root[k-1]);
      end
      for (int r = 0; r < 32; r++) begin
         t = 64'd1 << 62;
         for (int k = 0; k < 5; k++) begin
            if (r[k]) begin
               t = mul_q62(t, root[5-k]);
            end
         end
         tab[r] = t;
      end
      return tab;
   endfunction

   localparam pow_tab_type POW_TAB = build_pow_tab();

   // Only the bits at and above the smallest rounding point are kept.
   function automatic amp_tab_type build_amp_tab(pow_tab_type pw);
      amp_tab_type tab;
      for (int r = 0; r < 32; r++) begin
         tab[r] = pw[r][62:46];
      end
      return tab;
   endfunction

   // Frequency scale is five times the power, taken after dropping eight bits.
   function automatic freq_tab_type build_freq_tab(pow_tab_type pw);
      logic [63:0]  m;
      freq_tab_type tab;
      for (int r = 0; r < 32; r++) begin
         m      = (pw[r] >> 8) * 64'd5;
         tab[r] = m[57:40];
      end
      return tab;
   endfunction

   localparam amp_tab_type  AMP_TAB  = build_amp_tab(POW_TAB);
   localparam freq_tab_type FREQ_TAB = build_freq_tab(POW_TAB);

   function automatic logic signed [8:0] am7_map(logic [6:0] c);
      logic signed [9:0] w;
      case (c) inside
         7'd0:           w = {AMP_DFLT[8], AMP_DFLT};
         [7'd1:7'd15]:   w = $signed({3'b000, c}) * 10'sd8 - 10'sd248;
         [7'd16:7'd31]:  w = $signed({3'b000, c}) * 10'sd2 - 10'sd158;
         default:        w = $signed({3'b000, c}) - 10'sd127;
      endcase
      return w[8:0];
   endfunction

   function automatic logic signed [7:0] fm7_map(logic [6:0] c);
      return $signed({1'b0, c}) - 8'sd64;
   endfunction

   function automatic logic signed [8:0] amp_apply(act_type act, logic signed [8:0] val,
                                                   logic signed [8:0] cur);
      logic signed [9:0] s;
      logic signed [8:0] r;
      s = $signed({cur[8], cur}) + $signed({val[8], val});
      case (act)
         ACT_KEEP:  r = cur;
         ACT_SUBST: r = val;
         ACT_ADD: begin
            if (s < $signed({AMP_DFLT[8], AMP_DFLT})) begin
               r = AMP_DFLT;
            end else if (s > $signed({AMP_MAX[8], AMP_MAX})) begin
               r = AMP_MAX;
            end else begin
               r = s[8:0];
            end
         end
         default:   r = AMP_DFLT;
      endcase
      return r;
   endfunction

   function automatic logic signed [7:0] freq_apply(act_type act, logic signed [4:0] val,
                                                    logic signed [7:0] cur);
      logic signed [8:0] s;
      logic signed [7:0] r;
      s = $signed({cur[7], cur}) + $signed({{4{val[4]}}, val});
      case (act)
         ACT_KEEP:  r = cur;
         ACT_SUBST: r = {{3{val[4]}}, val};
         ACT_ADD: begin
            if (s < FREQ_MIN) begin
               r = FREQ_MIN[7:0];
            end else if (s > FREQ_MAX) begin
               r = FREQ_MAX[7:0];
            end else begin
               r = s[7:0];
            end
         end
         default:   r = FREQ_DFLT;
      endcase
      return r;
   endfunction

   // Log amplitude in 1/32 steps to unsigned Q1.15, rounded to nearest.
   function automatic logic [15:0] amp_conv(logic signed [8:0] x);
      logic [8:0]  u;
      logic [3:0]  sh;
      logic [16:0] v;
      logic [17:0] s;
      // Adding 256 to a value in -256..0 only flips the sign bit.
      u  = {~x[8], x[7:0]};
      sh = 4'd8 - u[8:5];
      v  = AMP_TAB[u[4:0]] >> sh;
      s  = {1'b0, v} + 18'd1;
      return (u < AMP_FLOOR_U) ? 16'd0 : s[16:1];
   endfunction

   // Log frequency in 1/32 steps to 1/32 Hz; the high band sits one octave up.
   function automatic logic [15:0] freq_conv(logic signed [7:0] x, logic high);
      logic [7:0]  u;
      logic [2:0]  sh;
      logic [17:0] v;
      logic [18:0] s;
      u  = x + 8'd64;
      sh = (high ? 3'd4 : 3'd5) - u[7:5];
      v  = FREQ_TAB[u[4:0]] >> sh;
      s  = {1'b0, v} + 19'd1;
      return s[16:1];
   endfunction

endpackage

@@ rtl/core/vibration_amfm_packet_decoder_core.sv @@
// Two-band vibration packet decoder: command and code updates, log-to-linear output.
//
// Each accepted packet word updates four log-domain registers (low and high band
// amplitude and frequency) in up to three steps and sends one sample word per
// step: one for the one5 and one7 formats, two for two5 and two7, three for three5
// and three7, none for the none format or the unused op value. The decoder takes
// one step per cycle while the sample slot is free or draining, so a packet
// occupies the input register until its last step is taken, and a one-sample
// packet can follow every cycle under the same condition. Each step writes the
// log registers; their values are converted to linear through a 32-entry
// power-of-two constant table as they are loaded into the result register.
// The last sample of a packet carries rsp_tlast.
module vibration_amfm_packet_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // code_lo_0, code_hi_0, code_lo_1, code_hi_1, code_lo_2, code_hi_2,
   // am7_lo, fm7_lo, am7_hi, fm7_hi, zero fill
   input  logic [vamfm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op, target, zero fill
   input  logic [vamfm_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // low_amp, low_freq, high_amp, high_freq, zero fill
   output logic [vamfm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast
);
   import vamfm_pkg::*;

   pkt_type           pkt_in, pkt_ff;
   logic              pkt_vld_in, pkt_vld_ff;
   logic [1:0]        step_in, step_ff;
   step_ctl_type      ctl;
   logic [4:0]        cmd_lo, cmd_hi;
   logic              advance, done;

   logic signed [8:0] la_load, ha_load;
   logic signed [7:0] lf_load, hf_load;
   logic signed [8:0] la_in, la_ff, ha_in, ha_ff;
   logic signed [7:0] lf_in, lf_ff, hf_in, hf_ff;

   logic              snap_vld_in, snap_vld_ff;
   logic              snap_last_in, snap_last_ff;
   logic              snap_rdy;

   logic              rsp_vld_in, rsp_vld_ff;
   logic              rsp_rdy, rsp_load;
   logic [RSP_DATA_W-1:0] rsp_data_in, rsp_data_ff;
   logic              rsp_last_in, rsp_last_ff;
   logic [15:0]       low_amp, high_amp, high_freq, low_freq_w;

   // Incoming word, unpacked.
   always_comb begin
      pkt_in.op         = op_type'(req_tuser[2:0]);
      pkt_in.target     = req_tuser[4:3];
      pkt_in.code_lo[0] = req_tdata[4:0];
      pkt_in.code_hi[0] = req_tdata[9:5];
      pkt_in.code_lo[1] = req_tdata[14:10];
      pkt_in.code_hi[1] = req_tdata[19:15];
      pkt_in.code_lo[2] = req_tdata[24:20];
      pkt_in.code_hi[2] = req_tdata[29:25];
      pkt_in.am7_lo     = req_tdata[36:30];
      pkt_in.fm7_lo     = req_tdata[43:37];
      pkt_in.am7_hi     = req_tdata[50:44];
      pkt_in.fm7_hi     = req_tdata[57:51];
   end

   // Step decode for the packet held in the input register.
   always_comb begin
      ctl    = '0;
      cmd_lo = pkt_ff.code_lo[step_ff];
      cmd_hi = pkt_ff.code_hi[step_ff];
      case (pkt_ff.op)
         OP_ONE5: begin
            ctl.emit      = 1'b1;
            ctl.last      = 1'b1;
            ctl.cmd_lo_en = 1'b1;
            ctl.cmd_hi_en = 1'b1;
         end
         OP_ONE7: begin
            ctl.emit  = 1'b1;
            ctl.last  = 1'b1;
            ctl.ld_la = 1'b1;
            ctl.ld_lf = 1'b1;
            ctl.ld_ha = 1'b1;
            ctl.ld_hf = 1'b1;
         end
         OP_THREE7: begin
            ctl.emit = 1'b1;
            ctl.last = (step_ff == 2'd2);
            if (step_ff == 2'd0) begin
               ctl.ld_la = !pkt_ff.target[1] && !pkt_ff.target[0];
               ctl.ld_lf = !pkt_ff.target[1] &&  pkt_ff.target[0];
               ctl.ld_ha =  pkt_ff.target[1] && !pkt_ff.target[0];
               ctl.ld_hf =  pkt_ff.target[1] &&  pkt_ff.target[0];
            end else begin
               ctl.cmd_lo_en = 1'b1;
               ctl.cmd_hi_en = 1'b1;
            end
         end
         OP_TWO5: begin
            ctl.emit      = 1'b1;
            ctl.last      = (step_ff == 2'd1);
            ctl.cmd_lo_en = 1'b1;
            ctl.cmd_hi_en = 1'b1;
         end
         OP_TWO7: begin
            ctl.emit = 1'b1;
            ctl.last = (step_ff == 2'd1);
            if (step_ff == 2'd0) begin
               // One band is loaded from the codes, the other takes the first command.
               if (pkt_ff.target[1]) begin
                  ctl.ld_ha     = 1'b1;
                  ctl.ld_hf     = 1'b1;
                  ctl.cmd_lo_en = 1'b1;
               end else begin
                  ctl.ld_la     = 1'b1;
                  ctl.ld_lf     = 1'b1;
                  ctl.cmd_hi_en = 1'b1;
                  cmd_hi        = pkt_ff.code_lo[0];
               end
            end else begin
               ctl.cmd_lo_en = 1'b1;
               ctl.cmd_hi_en = 1'b1;
            end
         end
         OP_THREE5: begin
            ctl.emit      = 1'b1;
            ctl.last      = (step_ff == 2'd2);
            ctl.cmd_lo_en = 1'b1;
            ctl.cmd_hi_en = 1'b1;
         end
         default: ;
      endcase
   end

   // Absolute values from the 7-bit codes.
   always_comb begin
      la_load = am7_map(pkt_ff.am7_lo);
      ha_load = am7_map((pkt_ff.op == OP_ONE7) ? pkt_ff.am7_hi : pkt_ff.am7_lo);
      lf_load = fm7_map((pkt_ff.op == OP_THREE7) ? pkt_ff.am7_lo : pkt_ff.fm7_lo);
      if (pkt_ff.op == OP_ONE7) begin
         hf_load = fm7_map(pkt_ff.fm7_hi);
      end else if (pkt_ff.op == OP_THREE7) begin
         hf_load = fm7_map(pkt_ff.am7_lo);
      end else begin
         hf_load = fm7_map(pkt_ff.fm7_lo);
      end
   end

   // Handshake: a step goes ahead when the sample slot is free or draining.
   always_comb begin
      rsp_rdy    = !rsp_vld_ff || rsp_tready;
      snap_rdy   = !snap_vld_ff || rsp_rdy;
      advance    = pkt_vld_ff && ctl.emit && snap_rdy;
      done       = pkt_vld_ff && (!ctl.emit || (snap_rdy && ctl.last));
      req_tready = !reset && (!pkt_vld_ff || done);
      rsp_load   = snap_vld_ff && rsp_rdy;
   end

   always_comb begin
      pkt_vld_in = pkt_vld_ff;
      step_in    = step_ff;
      if (req_tvalid && req_tready) begin
         pkt_vld_in = 1'b1;
         step_in    = 2'd0;
      end else if (done) begin
         pkt_vld_in = 1'b0;
      end else if (advance) begin
         step_in = step_ff + 2'd1;
      end
   end

   // Register update for one step.
   always_comb begin
      la_in = la_ff;
      lf_in = lf_ff;
      ha_in = ha_ff;
      hf_in = hf_ff;
      if (advance) begin
         if (ctl.ld_la) begin
            la_in = la_load;
         end else if (ctl.cmd_lo_en) begin
            la_in = amp_apply(AM_ACT[cmd_lo], AM_VAL[cmd_lo], la_ff);
         end
         if (ctl.ld_lf) begin
            lf_in = lf_load;
         end else if (ctl.cmd_lo_en) begin
            lf_in = freq_apply(FM_ACT[cmd_lo], FM_VAL[cmd_lo], lf_ff);
         end
         if (ctl.ld_ha) begin
            ha_in = ha_load;
         end else if (ctl.cmd_hi_en) begin
            ha_in = amp_apply(AM_ACT[cmd_hi], AM_VAL[cmd_hi], ha_ff);
         end
         if (ctl.ld_hf) begin
            hf_in = hf_load;
         end else if (ctl.cmd_hi_en) begin
            hf_in = freq_apply(FM_ACT[cmd_hi], FM_VAL[cmd_hi], hf_ff);
         end
      end
   end

   // The log registers hold the pending sample until it moves to the result register.
   always_comb begin
      snap_vld_in  = snap_vld_ff;
      snap_last_in = snap_last_ff;
      if (advance) begin
         snap_vld_in  = 1'b1;
         snap_last_in = ctl.last;
      end else if (rsp_load) begin
         snap_vld_in = 1'b0;
      end
   end

   always_comb begin
      low_amp     = amp_conv(la_ff);
      low_freq_w  = freq_conv(lf_ff, 1'b0);
      high_amp    = amp_conv(ha_ff);
      high_freq   = freq_conv(hf_ff, 1'b1);
      rsp_data_in = {1'b0, high_freq, high_amp, low_freq_w[14:0], low_amp};
      rsp_last_in = snap_last_ff;
      rsp_vld_in  = rsp_load || (rsp_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_vld_ff  <= 1'b0;
         step_ff     <= 2'd0;
         snap_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         la_ff       <= AMP_DFLT;
         lf_ff       <= FREQ_DFLT;
         ha_ff       <= AMP_DFLT;
         hf_ff       <= FREQ_DFLT;
      end else begin
         pkt_vld_ff  <= pkt_vld_in;
         step_ff     <= step_in;
         snap_vld_ff <= snap_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         la_ff       <= la_in;
         lf_ff       <= lf_in;
         ha_ff       <= ha_in;
         hf_ff       <= hf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         pkt_ff <= pkt_in;
      end
      snap_last_ff <= snap_last_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/core/vamfm_checker.sv @@
// Port-level checks of the vibration packet decoder and their binding.
`include "vibration_amfm_packet_decoder_core_assert.svh"

module vamfm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [vamfm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tlast
);
   import vamfm_pkg::*;

   // No sample word may survive a reset.
   `VAMFM_ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_tvalid, "sample after reset")

   // A stalled sample word keeps its contents.
   `VAMFM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled sample changed")

   // Every field stays within the range of the log registers after conversion.
   `VAMFM_ASSERT_SAME(a_rsp_range, clock, reset, rsp_tvalid,
      rsp_tdata[15:0] <= AMP_ONE && rsp_tdata[30:16] <= LOW_FREQ_MAX &&
      rsp_tdata[46:31] <= AMP_ONE && rsp_tdata[62:47] <= HIGH_FREQ_MAX && !rsp_tdata[63],
      "sample field out of range")

endmodule

bind vibration_amfm_packet_decoder_core vamfm_checker u_vamfm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/vibration_amfm_packet_decoder_core_tb.sv @@
// Self-checking testbench of the vibration packet decoder with its own sample predictor.
module vibration_amfm_packet_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vamfm_pkg::*;

   localparam logic [2:0] OP_SPARE = 3'd7;

   // Input packet, one field per command or code.
   typedef struct packed {
      logic [2:0] op;
      logic [1:0] target;
      logic [4:0] lo0;
      logic [4:0] hi0;
      logic [4:0] lo1;
      logic [4:0] hi1;
      logic [4:0] lo2;
      logic [4:0] hi2;
      logic [6:0] am_lo;
      logic [6:0] fm_lo;
      logic [6:0] am_hi;
      logic [6:0] fm_hi;
   } packet_type;

   typedef struct packed {
      logic [15:0] low_amp;
      logic [14:0] low_freq;
      logic [15:0] high_amp;
      logic [15:0] high_freq;
      logic        last;
   } sample_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [7:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;

   vibration_amfm_packet_decoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Command tables: amplitude and frequency action of each 5-bit command.
   act_type am_kind [32] = '{
      ACT_DFLT,  ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_SUBST,
      ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,
      ACT_KEEP,  ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_KEEP,
      ACT_KEEP,  ACT_KEEP,  ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_ADD,   ACT_ADD
   };
   int am_delta [32] = '{
      0, 0, -16, -32, -48, -64, -80, -96, -112, -128, -144, -160, 0, 0, 0, 0,
      0, 4, 4, 4, 1, 1, 1, 0, 0, 0, -1, -1, -1, -4, -4, -4
   };
   act_type fm_kind [32] = '{
      ACT_DFLT,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,
      ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_KEEP,  ACT_SUBST, ACT_SUBST, ACT_SUBST, ACT_SUBST,
      ACT_SUBST, ACT_ADD,   ACT_KEEP,  ACT_ADD,   ACT_ADD,   ACT_KEEP,  ACT_ADD,   ACT_ADD,
      ACT_KEEP,  ACT_ADD,   ACT_ADD,   ACT_KEEP,  ACT_ADD,   ACT_ADD,   ACT_KEEP,  ACT_ADD
   };
   int fm_delta [32] = '{
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, -12, -6, 0, 6,
      12, 1, 0, -1, 1, 0, -1, 1, 0, -1, 1, 0, -1, 1, 0, -1
   };

   logic [63:0] pow2_frac [32];   // 2^(r/32) in Q2.62

   int low_amp_lg = -256;
   int low_freq_lg = 0;
   int high_amp_lg = -256;
   int high_freq_lg = 0;

   packet_type pending_packets [$];
   sample_type samples_due [$];
   packet_type drv_pkt = '0;
   logic    req_taken = 1'b0;
   int      items_queued = 0;
   int      items_taken = 0;
   int      samples_seen = 0;
   int      mismatch_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   logic    hold_req = 1'b0;
   logic    hold_on = 1'b0;

   function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      prod = prod + (128'd1 << 61);
      return prod[125:62];
   endfunction

   // Largest Q2.62 value whose square does not exceed v.
   function automatic logic [63:0] q62_sqrt(logic [63:0] v);
      logic [127:0] goal;
      logic [127:0] sq;
      logic [63:0]  lo;
      logic [63:0]  hi;
      logic [63:0]  mid;
      goal = {2'b00, v, 62'd0};
      lo = 64'd1 << 62;
      hi = (64'd1 << 63) - 64'd1;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 64'd1) >> 1);
         sq = {64'd0, mid} * {64'd0, mid};
         if (sq <= goal) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      return lo;
   endfunction

   task automatic fill_pow2_table();
      logic [63:0] root [6];
      logic [63:0] acc;
      root[0] = 64'd1 << 63;
      for (int k = 1; k < 6; k++) root[k] = q62_sqrt(root[k-1]);
      for (int r = 0; r < 32; r++) begin
         acc = 64'd1 << 62;
         for (int k = 0; k < 5; k++) begin
            if (r[k]) acc = q62_mul(acc, root[5-k]);
         end
         pow2_frac[r] = acc;
      end
   endtask

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int next_log(act_type kind, int delta, int cur, int dflt, int lo, int hi);
      case (kind)
         ACT_KEEP:  return cur;
         ACT_SUBST: return delta;
         ACT_ADD:   return clamp(cur + delta, lo, hi);
         default:   return dflt;
      endcase
   endfunction

   function automatic int am_code(logic [6:0] c);
      int v;
      v = c;
      if (v == 0) return -256;
      if (v < 16) return 8 * v - 248;
      if (v < 32) return 2 * v - 158;
      return v - 127;
   endfunction

   function automatic int fm_code(logic [6:0] c);
      int v;
      v = c;
      return v - 64;
   endfunction

   // Amplitudes below the floor of -254 come out as zero.
   function automatic logic [15:0] amp_lin(int x);
      int          u;
      int          sh;
      logic [63:0] r;
      if (x < -254) return 16'd0;
      if (x > 0) return 16'd32768;
      u = x + 256;
      sh = 47 - ((u >> 5) - 8);
      r = (pow2_frac[u & 31] + (64'd1 << (sh - 1))) >> sh;
      return r[15:0];
   endfunction

   // base_shift is 44 around 160 Hz and 43 around 320 Hz.
   function automatic logic [15:0] freq_lin(int x, int base_shift);
      int          u;
      int          sh;
      logic [63:0] m;
      logic [63:0] r;
      u = x + 64;
      sh = base_shift - ((u >> 5) - 2);
      m = (pow2_frac[u & 31] >> 8) * 64'd5;
      r = (m + (64'd1 << (sh - 1))) >> sh;
      return r[15:0];
   endfunction

   task automatic band_cmd(input logic [4:0] c, inout int amp, inout int frq);
      amp = next_log(am_kind[c], am_delta[c], amp, -256, -256, 0);
      frq = next_log(fm_kind[c], fm_delta[c], frq, 0, -64, 64);
   endtask

   task automatic cmd_both(input logic [4:0] clo, input logic [4:0] chi);
      band_cmd(clo, low_amp_lg, low_freq_lg);
      band_cmd(chi, high_amp_lg, high_freq_lg);
   endtask

   task automatic emit_sample(input logic last);
      sample_type s;
      logic [15:0] lf;
      lf = freq_lin(low_freq_lg, 44);
      s.low_amp = amp_lin(low_amp_lg);
      s.low_freq = lf[14:0];
      s.high_amp = amp_lin(high_amp_lg);
      s.high_freq = freq_lin(high_freq_lg, 43);
      s.last = last;
      samples_due.push_back(s);
   endtask

   task automatic predict_packet(input packet_type p);
      case (p.op)
         OP_ONE5: begin
            cmd_both(p.lo0, p.hi0);
            emit_sample(1'b1);
         end
         OP_ONE7: begin
            low_amp_lg = am_code(p.am_lo);
            low_freq_lg = fm_code(p.fm_lo);
            high_amp_lg = am_code(p.am_hi);
            high_freq_lg = fm_code(p.fm_hi);
            emit_sample(1'b1);
         end
         OP_THREE7: begin
            // One code, steered to a single register by target.
            case (p.target)
               2'b00: low_amp_lg = am_code(p.am_lo);
               2'b01: low_freq_lg = fm_code(p.am_lo);
               2'b10: high_amp_lg = am_code(p.am_lo);
               default: high_freq_lg = fm_code(p.am_lo);
            endcase
            emit_sample(1'b0);
            cmd_both(p.lo1, p.hi1);
            emit_sample(1'b0);
            cmd_both(p.lo2, p.hi2);
            emit_sample(1'b1);
         end
         OP_TWO5: begin
            cmd_both(p.lo0, p.hi0);
            emit_sample(1'b0);
            cmd_both(p.lo1, p.hi1);
            emit_sample(1'b1);
         end
         OP_TWO7: begin
            // The codes load one band; the first command goes to the other one.
            if (p.target[1]) begin
               high_amp_lg = am_code(p.am_lo);
               high_freq_lg = fm_code(p.fm_lo);
               band_cmd(p.lo0, low_amp_lg, low_freq_lg);
            end else begin
               low_amp_lg = am_code(p.am_lo);
               low_freq_lg = fm_code(p.fm_lo);
               band_cmd(p.lo0, high_amp_lg, high_freq_lg);
            end
            emit_sample(1'b0);
            cmd_both(p.lo1, p.hi1);
            emit_sample(1'b1);
         end
         OP_THREE5: begin
            cmd_both(p.lo0, p.hi0);
            emit_sample(1'b0);
            cmd_both(p.lo1, p.hi1);
            emit_sample(1'b0);
            cmd_both(p.lo2, p.hi2);
            emit_sample(1'b1);
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("sample %0d: %s got %0d, want %0d", samples_seen, what, got, want);
   endtask

   task automatic check_sample(input sample_type want);
      if (rsp_tdata[15:0] !== want.low_amp)
         report_mismatch("low_amp", rsp_tdata[15:0], want.low_amp);
      if (rsp_tdata[30:16] !== want.low_freq)
         report_mismatch("low_freq", rsp_tdata[30:16], want.low_freq);
      if (rsp_tdata[46:31] !== want.high_amp)
         report_mismatch("high_amp", rsp_tdata[46:31], want.high_amp);
      if (rsp_tdata[62:47] !== want.high_freq)
         report_mismatch("high_freq", rsp_tdata[62:47], want.high_freq);
      if (rsp_tlast !== want.last)
         report_mismatch("last", rsp_tlast, want.last);
   endtask

   task automatic queue_item(input packet_type p);
      pending_packets.push_back(p);
      items_queued++;
   endtask

   task automatic queue_fields(input logic [2:0] op, input logic [1:0] tgt,
                               input logic [4:0] l0, input logic [4:0] h0,
                               input logic [4:0] l1, input logic [4:0] h1,
                               input logic [4:0] l2, input logic [4:0] h2,
                               input logic [6:0] al, input logic [6:0] fl,
                               input logic [6:0] ah, input logic [6:0] fh);
      packet_type p;
      p = '{op, tgt, l0, h0, l1, h1, l2, h2, al, fl, ah, fh};
      queue_item(p);
   endtask

   // Mostly add commands so that the registers drift into their clamps.
   function automatic logic [4:0] random_cmd();
      if ($urandom_range(99) < 60) return 5'($urandom_range(17, 31));
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic logic [6:0] random_code();
      logic [6:0] edges [7];
      edges = '{7'd0, 7'd1, 7'd15, 7'd16, 7'd31, 7'd32, 7'd127};
      if ($urandom_range(99) < 20) return edges[$urandom_range(6)];
      return 7'($urandom_range(0, 127));
   endfunction

   function automatic packet_type random_packet();
      packet_type p;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 4) p.op = OP_NONE;
      else if (pick < 6) p.op = OP_SPARE;
      else p.op = 3'($urandom_range(1, 6));
      p.target = 2'($urandom_range(0, 3));
      p.lo0 = random_cmd();
      p.hi0 = random_cmd();
      p.lo1 = random_cmd();
      p.hi1 = random_cmd();
      p.lo2 = random_cmd();
      p.hi2 = random_cmd();
      p.am_lo = random_code();
      p.fm_lo = random_code();
      p.am_hi = random_code();
      p.fm_hi = random_code();
      return p;
   endfunction

   task automatic queue_random(input int count);
      packet_type p;
      int      useful;
      useful = 0;
      while (useful < count) begin
         p = random_packet();
         queue_item(p);
         if (p.op != OP_NONE && p.op != OP_SPARE) useful++;
      end
   endtask

   task automatic wait_drained();
      while (items_taken != items_queued || samples_due.size() != 0) @(negedge clock);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // Packet sender: a new word goes out once the previous one was taken.
   always @(negedge clock) begin : drive_req
      packet_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_packets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_packets.pop_front();
            drv_pkt <= nxt;
            req_tdata <= {6'd0, nxt.fm_hi, nxt.am_hi, nxt.fm_lo, nxt.am_lo,
                          nxt.hi2, nxt.lo2, nxt.hi1, nxt.lo1, nxt.hi0, nxt.lo0};
            req_tuser <= {3'd0, nxt.target, nxt.op};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Long hold-off of the sample side while packets keep coming.
   initial begin
      wait (hold_req);
      @(posedge clock);
      hold_on = 1'b1;
      repeat (300) @(posedge clock);
      hold_on = 1'b0;
   end

   always @(posedge clock) begin : watch
      sample_type want;
      if (reset) begin
         req_taken <= 1'b0;
         low_amp_lg = -256;
         low_freq_lg = 0;
         high_amp_lg = -256;
         high_freq_lg = 0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            predict_packet(drv_pkt);
            items_taken <= items_taken + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (samples_due.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata, 0);
            end else begin
               want = samples_due.pop_front();
               check_sample(want);
            end
            samples_seen++;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("vibration_amfm_packet_decoder_core: mismatch");
      $finish;
   end

   initial begin
      fill_pow2_table();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Defaults, then both code extremes on both bands.
      queue_fields(OP_ONE5, 2'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 7'd0, 7'd0, 7'd0, 7'd0);
      queue_fields(OP_ONE7, 2'd3, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
                   7'd0, 7'd0, 7'd127, 7'd127);
      queue_fields(OP_ONE7, 2'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
                   7'd127, 7'd127, 7'd0, 7'd0);
      // Additions that run into the upper and lower clamps.
      queue_fields(OP_ONE5, 2'd0, 5'd17, 5'd17, 5'd0, 5'd0, 5'd0, 5'd0, 7'd0, 7'd0, 7'd0, 7'd0);
      queue_fields(OP_ONE5, 2'd0, 5'd17, 5'd17, 5'd0, 5'd0, 5'd0, 5'd0, 7'd0, 7'd0, 7'd0, 7'd0);
      queue_fields(OP_ONE5, 2'd0, 5'd29, 5'd31, 5'd0, 5'd0, 5'd0, 5'd0, 7'd0, 7'd0, 7'd0, 7'd0);
      queue_fields(OP_ONE5, 2'd0, 5'd31, 5'd31, 5'd0, 5'd0, 5'd0, 5'd0, 7'd0, 7'd0, 7'd0, 7'd0);
      queue_fields(OP_ONE5, 2'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 7'd0, 7'd0, 7'd0, 7'd0);
      // Amplitude steps from -256 across the floor at -254.
      queue_fields(OP_THREE5, 2'd0, 5'd20, 5'd20, 5'd20, 5'd23, 5'd29, 5'd26,
                   7'd0, 7'd0, 7'd0, 7'd0);
      queue_fields(OP_TWO5, 2'd0, 5'd1, 5'd11, 5'd12, 5'd16, 5'd0, 5'd0,
                   7'd0, 7'd0, 7'd0, 7'd0);
      queue_fields(OP_TWO5, 2'd0, 5'd13, 5'd14, 5'd15, 5'd2, 5'd0, 5'd0,
                   7'd0, 7'd0, 7'd0, 7'd0);
      queue_fields(OP_THREE7, 2'd0, 5'd0, 5'd0, 5'd3, 5'd4, 5'd5, 5'd6,
                   7'd1, 7'd0, 7'd0, 7'd0);
      queue_fields(OP_THREE7, 2'd1, 5'd0, 5'd0, 5'd7, 5'd8, 5'd9, 5'd10,
                   7'd15, 7'd0, 7'd0, 7'd0);
      queue_fields(OP_THREE7, 2'd2, 5'd0, 5'd0, 5'd18, 5'd19, 5'd21, 5'd22,
                   7'd16, 7'd0, 7'd0, 7'd0);
      queue_fields(OP_THREE7, 2'd3, 5'd0, 5'd0, 5'd24, 5'd25, 5'd27, 5'd28,
                   7'd31, 7'd0, 7'd0, 7'd0);
      queue_fields(OP_TWO7, 2'd0, 5'd20, 5'd31, 5'd17, 5'd29, 5'd0, 5'd0,
                   7'd32, 7'd0, 7'd127, 7'd127);
      queue_fields(OP_TWO7, 2'd1, 5'd30, 5'd0, 5'd26, 5'd17, 5'd0, 5'd0,
                   7'd127, 7'd127, 7'd0, 7'd0);
      queue_fields(OP_TWO7, 2'd2, 5'd11, 5'd0, 5'd31, 5'd20, 5'd0, 5'd0,
                   7'd0, 7'd64, 7'd0, 7'd0);
      queue_fields(OP_TWO7, 2'd3, 5'd16, 5'd0, 5'd12, 5'd29, 5'd0, 5'd0,
                   7'd64, 7'd1, 7'd0, 7'd0);
      queue_fields(OP_ONE7, 2'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
                   7'd1, 7'd64, 7'd15, 7'd1);
      queue_fields(OP_ONE7, 2'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
                   7'd16, 7'd32, 7'd31, 7'd96);
      // Empty formats must leave the registers alone.
      queue_fields(OP_NONE, 2'd3, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
                   7'd127, 7'd127, 7'd127, 7'd127);
      queue_fields(OP_SPARE, 2'd3, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
                   7'd127, 7'd127, 7'd127, 7'd127);
      queue_fields(OP_ONE5, 2'd0, 5'd24, 5'd21, 5'd0, 5'd0, 5'd0, 5'd0,
                   7'd0, 7'd0, 7'd0, 7'd0);
      wait_drained();

      // Full rate, with a long sample-side hold-off at the start.
      queue_random(100);
      hold_req = 1'b1;
      wait_drained();

      send_idle_pct = 79;
      queue_random(100);
      wait_drained();

      send_idle_pct = 0;
      recv_stall_pct = 79;
      queue_random(100);
      wait_drained();

      send_idle_pct = 14;
      recv_stall_pct = 14;
      queue_random(100);
      wait_drained();

      // Catch any word the decoder sends beyond what was expected.
      repeat (16) @(negedge clock);
      if (mismatch_count == 0 && samples_due.size() == 0) begin
         $display("vibration_amfm_packet_decoder_core: match");
      end else begin
         $display("vibration_amfm_packet_decoder_core: mismatch");
      end
      $finish;
   end

endmodule
